// ===== rtl/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ZTOL_W         = 16;
    localparam int DTOL_W         = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int KIND_W         = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_TOL = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TWO_REAL = 3'd0,
        KIND_DOUBLE   = 3'd1,
        KIND_COMPLEX  = 3'd2,
        KIND_LINEAR   = 3'd3,
        KIND_ALL_REAL = 3'd4,
        KIND_NONE     = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  sa;
        logic  sb;
        logic  sc;
    } t_ctl;

endpackage

// ===== rtl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: config registers, root setup and output stage.
// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients and returns the root
// class and both roots, rounded to nearest and saturated to the output range. The block
// is fully pipelined and accepts one request per clock while the output is not stalled. Its
// stages are 3 front-end stages, DATA_WIDTH+1 square-root stages, one setup stage,
// FRAC_BITS+DATA_WIDTH+5 divider stages and one output register, from the bit-serial square
// root and restoring divider pipelines. A stall on the output freezes the whole pipeline.
// Configuration writes are to be issued only while no request is in flight.
module quadratic_root_solver #(
    parameter int DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]     i_coef_a,
    input  logic signed [DATA_WIDTH-1:0]     i_coef_b,
    input  logic signed [DATA_WIDTH-1:0]     i_coef_c,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [qrs_pkg::KIND_W-1:0]       o_root_kind,
    output logic signed [DATA_WIDTH-1:0]     o_root1_real,
    output logic signed [DATA_WIDTH-1:0]     o_root1_imag,
    output logic signed [DATA_WIDTH-1:0]     o_root2_real,
    output logic signed [DATA_WIDTH-1:0]     o_root2_imag,
    output logic                             o_saturated
);
    import qrs_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int DDW  = 2 * DW + 2;
    localparam int SW   = DW + 1;
    localparam int NW   = DW + 2;
    localparam int QW   = NW + FRAC_BITS + 2;
    localparam int CTLW = $bits(t_ctl);
    localparam int SBS  = CTLW + 3 * DW;

    logic [ZTOL_W-1:0] r_zero_tol;
    logic [DTOL_W-1:0] r_disc_tol;
    logic              en;

    // front end
    logic              f_valid;
    t_ctl              f_ctl;
    logic [DW-1:0]     f_ma, f_mb, f_mc;
    logic [DDW-1:0]    f_dmag;

    // square root
    logic              s_valid;
    logic [SW-1:0]     s_root;
    logic [SBS-1:0]    s_side;
    t_ctl              s_ctl;
    logic [DW-1:0]     s_ma, s_mb, s_mc;

    // setup for the divider
    logic              n_num_neg [0:2];
    logic [NW-1:0]     n_num_mag [0:2];
    logic              n_den_neg;
    logic [DW:0]       n_den_mag;
    logic [NW:0]       sum_p, sum_m;
    logic              r_dvalid;
    t_kind             r_dkind;
    logic              r_num_neg [0:2];
    logic [NW-1:0]     r_num_mag [0:2];
    logic              r_den_neg;
    logic [DW:0]       r_den_mag;

    // divider
    logic              d_valid;
    logic [KIND_W-1:0] d_side;
    logic              d_neg [0:2];
    logic [QW-1:0]     d_quo [0:2];

    // output
    logic [DW:0]       c0, c1, c2, c2n;
    t_kind             d_kind;
    t_kind             n_kind;
    logic [DW-1:0]     n_r1r, n_r1i, n_r2r, n_r2i;
    logic              n_sat;
    logic              r_out_valid;
    t_kind             r_kind;
    logic [DW-1:0]     r_r1r, r_r1i, r_r2r, r_r2i;
    logic              r_sat;

    function automatic logic [NW:0] sadd(input logic an, input logic [NW-1:0] am,
                                         input logic bn, input logic [NW-1:0] bm);
        logic [NW-1:0] m;
        logic          n;
        if (an == bn) begin
            m = am + bm;
            n = an;
        end else if (am >= bm) begin
            m = am - bm;
            n = an;
        end else begin
            m = bm - am;
            n = bn;
        end
        if (m == '0)
            n = 1'b0;
        return {n, m};
    endfunction

    // {saturated, value}
    function automatic logic [DW:0] clamp(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        logic [DW-1:0] v;
        logic          sat;
        lim = {{(QW-DW){1'b0}}, neg, {(DW-1){~neg}}};
        sat = q > lim;
        v   = sat ? lim[DW-1:0] : q[DW-1:0];
        return {sat, neg ? (~v + 1'b1) : v};
    endfunction

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol <= '0;
            r_disc_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZERO_TOL: r_zero_tol <= i_cfg_data[ZTOL_W-1:0];
                CFG_DISC_TOL: r_disc_tol <= i_cfg_data[DTOL_W-1:0];
            endcase
        end
    end

    qrs_front #(.DW(DW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_a        (i_coef_a),
        .i_b        (i_coef_b),
        .i_c        (i_coef_c),
        .i_zero_tol (r_zero_tol),
        .i_disc_tol (r_disc_tol),
        .o_valid    (f_valid),
        .o_ctl      (f_ctl),
        .o_ma       (f_ma),
        .o_mb       (f_mb),
        .o_mc       (f_mc),
        .o_dmag     (f_dmag)
    );

    qrs_sqrt #(.DW(DW), .SBW(SBS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_dmag),
        .i_side  ({f_ctl, f_ma, f_mb, f_mc}),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign {s_ctl, s_ma, s_mb, s_mc} = s_side;

    assign sum_p = sadd(!s_ctl.sb && s_mb != '0, NW'(s_mb), 1'b0, NW'(s_root));
    assign sum_m = sadd(!s_ctl.sb && s_mb != '0, NW'(s_mb), 1'b1, NW'(s_root));

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_num_neg[l] = 1'b0;
            n_num_mag[l] = '0;
        end
        n_den_neg = s_ctl.sa;
        n_den_mag = {s_ma, 1'b0};
        case (s_ctl.kind)
            KIND_TWO_REAL: begin
                {n_num_neg[0], n_num_mag[0]} = sum_p;
                {n_num_neg[1], n_num_mag[1]} = sum_m;
            end
            KIND_DOUBLE, KIND_COMPLEX: begin
                n_num_neg[0] = !s_ctl.sb && s_mb != '0;
                n_num_mag[0] = NW'(s_mb);
                n_num_mag[2] = NW'(s_root);
            end
            KIND_LINEAR: begin
                n_num_neg[0] = !s_ctl.sc && s_mc != '0;
                n_num_mag[0] = NW'(s_mc);
                n_den_neg    = s_ctl.sb;
                n_den_mag    = {1'b0, s_mb};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_dvalid <= 1'b0;
        else if (en)
            r_dvalid <= s_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dkind   <= s_ctl.kind;
            r_den_neg <= n_den_neg;
            r_den_mag <= n_den_mag;
            for (int l = 0; l < 3; l++) begin
                r_num_neg[l] <= n_num_neg[l];
                r_num_mag[l] <= n_num_mag[l];
            end
        end
    end

    qrs_div #(.DW(DW), .FB(FRAC_BITS), .SBW(KIND_W)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_dvalid),
        .i_side    (r_dkind),
        .i_num_neg (r_num_neg),
        .i_num_mag (r_num_mag),
        .i_den_neg (r_den_neg),
        .i_den_mag (r_den_mag),
        .o_valid   (d_valid),
        .o_side    (d_side),
        .o_neg     (d_neg),
        .o_quo     (d_quo)
    );

    assign d_kind = t_kind'(d_side);
    assign c0     = clamp(d_neg[0], d_quo[0]);
    assign c1     = clamp(d_neg[1], d_quo[1]);
    assign c2     = clamp(d_neg[2], d_quo[2]);
    assign c2n    = clamp(!d_neg[2], d_quo[2]);

    always_comb begin
        n_kind = d_kind;
        n_r1r  = '0;
        n_r1i  = '0;
        n_r2r  = '0;
        n_r2i  = '0;
        n_sat  = 1'b0;
        case (d_kind)
            KIND_TWO_REAL: begin
                n_r1r = c0[DW-1:0];
                n_r2r = c1[DW-1:0];
                n_sat = c0[DW] | c1[DW];
            end
            KIND_DOUBLE: begin
                n_r1r = c0[DW-1:0];
                n_r2r = c0[DW-1:0];
                n_sat = c0[DW];
            end
            KIND_COMPLEX: begin
                n_r1r = c0[DW-1:0];
                n_r2r = c0[DW-1:0];
                n_r1i = c2[DW-1:0];
                n_r2i = c2n[DW-1:0];
                n_sat = c0[DW] | c2[DW] | c2n[DW];
            end
            KIND_LINEAR: begin
                n_r1r = c0[DW-1:0];
                n_sat = c0[DW];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (en)
            r_out_valid <= d_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind <= n_kind;
            r_r1r  <= n_r1r;
            r_r1i  <= n_r1i;
            r_r2r  <= n_r2r;
            r_r2i  <= n_r2i;
            r_sat  <= n_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_root_kind  = r_kind;
    assign o_root1_real = r_r1r;
    assign o_root1_imag = r_r1i;
    assign o_root2_real = r_r2r;
    assign o_root2_imag = r_r2i;
    assign o_saturated  = r_sat;

endmodule

// ===== rtl/qrs_front.sv =====
// Front end: coefficient decode, products, discriminant and root classification.
module qrs_front #(
    parameter int DW = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [DW-1:0]         i_a,
    input  logic signed [DW-1:0]         i_b,
    input  logic signed [DW-1:0]         i_c,
    input  logic [qrs_pkg::ZTOL_W-1:0]   i_zero_tol,
    input  logic [qrs_pkg::DTOL_W-1:0]   i_disc_tol,
    output logic                         o_valid,
    output qrs_pkg::t_ctl                o_ctl,
    output logic [DW-1:0]                o_ma,
    output logic [DW-1:0]                o_mb,
    output logic [DW-1:0]                o_mc,
    output logic [2*DW+1:0]              o_dmag
);
    import qrs_pkg::*;

    localparam int PW  = 2 * DW;
    localparam int DDW = 2 * DW + 2;

    logic [DW-1:0]  n1_ma, n1_mb, n1_mc;
    logic [DW-1:0]  r1_ma, r1_mb, r1_mc;
    logic           r1_valid, r1_za, r1_zb, r1_zc;
    t_ctl           r1_ctl;

    logic [PW-1:0]  r2_bb, r2_ac;
    logic [DW-1:0]  r2_ma, r2_mb, r2_mc;
    logic           r2_valid, r2_za, r2_zb, r2_zc;
    t_ctl           r2_ctl;

    logic [DDW-1:0] n3_dmag, ac4, bb, tol;
    logic           n3_dneg;
    t_ctl           n3_ctl;
    logic [DDW-1:0] r3_dmag;
    logic [DW-1:0]  r3_ma, r3_mb, r3_mc;
    logic           r3_valid;
    t_ctl           r3_ctl;

    assign n1_ma = i_a[DW-1] ? (~i_a + 1'b1) : i_a;
    assign n1_mb = i_b[DW-1] ? (~i_b + 1'b1) : i_b;
    assign n1_mc = i_c[DW-1] ? (~i_c + 1'b1) : i_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ma      <= n1_ma;
            r1_mb      <= n1_mb;
            r1_mc      <= n1_mc;
            r1_za      <= n1_ma <= DW'(i_zero_tol);
            r1_zb      <= n1_mb <= DW'(i_zero_tol);
            r1_zc      <= n1_mc <= DW'(i_zero_tol);
            r1_ctl.kind <= KIND_NONE;
            r1_ctl.sa  <= i_a[DW-1];
            r1_ctl.sb  <= i_b[DW-1];
            r1_ctl.sc  <= i_c[DW-1];

            r2_bb  <= r1_mb * r1_mb;
            r2_ac  <= r1_ma * r1_mc;
            r2_ma  <= r1_ma;
            r2_mb  <= r1_mb;
            r2_mc  <= r1_mc;
            r2_za  <= r1_za;
            r2_zb  <= r1_zb;
            r2_zc  <= r1_zc;
            r2_ctl <= r1_ctl;

            r3_dmag <= n3_dmag;
            r3_ma   <= r2_ma;
            r3_mb   <= r2_mb;
            r3_mc   <= r2_mc;
            r3_ctl  <= n3_ctl;
        end
    end

    assign ac4 = {r2_ac, 2'b00};
    assign bb  = DDW'(r2_bb);
    assign tol = DDW'(i_disc_tol);

    always_comb begin
        n3_dneg = 1'b0;
        if (r2_ctl.sa == r2_ctl.sc) begin
            if (ac4 > bb) begin
                n3_dneg = 1'b1;
                n3_dmag = ac4 - bb;
            end else begin
                n3_dmag = bb - ac4;
            end
        end else begin
            n3_dmag = bb + ac4;
        end

        n3_ctl = r2_ctl;
        if (r2_za) begin
            if (r2_zb)
                n3_ctl.kind = r2_zc ? KIND_ALL_REAL : KIND_NONE;
            else
                n3_ctl.kind = KIND_LINEAR;
        end else if (!n3_dneg && n3_dmag > tol) begin
            n3_ctl.kind = KIND_TWO_REAL;
        end else if (!n3_dneg || n3_dmag <= tol) begin
            n3_ctl.kind = KIND_DOUBLE;
        end else begin
            n3_ctl.kind = KIND_COMPLEX;
        end
    end

    assign o_valid = r3_valid;
    assign o_ctl   = r3_ctl;
    assign o_ma    = r3_ma;
    assign o_mb    = r3_mb;
    assign o_mc    = r3_mc;
    assign o_dmag  = r3_dmag;

endmodule

// ===== rtl/qrs_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt #(
    parameter int DW  = 32,
    parameter int SBW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*DW+1:0]   i_rad,
    input  logic [SBW-1:0]    i_side,
    output logic              o_valid,
    output logic [DW:0]       o_root,
    output logic [SBW-1:0]    o_side
);
    import qrs_pkg::*;

    localparam int SW  = DW + 1;
    localparam int RAW = 2 * SW;
    localparam int RW  = SW + 3;

    logic           r_valid [1:SW];
    logic [SW-1:0]  r_root  [1:SW];
    logic [SBW-1:0] r_side  [1:SW];
    logic [RW-1:0]  r_rem   [1:SW-1];
    logic [RAW-1:0] r_rad   [1:SW-1];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [RW-1:0]  rem_in, cur, trial;
        logic [SW-1:0]  root_in;
        logic [RAW-1:0] rad_in;
        logic [SBW-1:0] side_in;
        logic           v_in, ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign rad_in  = r_rad[k];
            assign side_in = r_side[k];
            assign v_in    = r_valid[k];
        end

        assign cur   = {rem_in[RW-3:0], rad_in[RAW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_valid[k+1] <= 1'b0;
            else if (i_en)
                r_valid[k+1] <= v_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= {root_in[SW-2:0], ge};
                r_side[k+1] <= side_in;
            end
        end

        if (k < SW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? (cur - trial) : cur;
                    r_rad[k+1] <= {rad_in[RAW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_valid = r_valid[SW];
    assign o_root  = r_root[SW];
    assign o_side  = r_side[SW];

endmodule

// ===== rtl/qrs_div.sv =====
// Pipelined rounding divider, three numerator lanes over one shared denominator.
module qrs_div #(
    parameter int DW  = 32,
    parameter int FB  = 16,
    parameter int SBW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [SBW-1:0]        i_side,
    input  logic                  i_num_neg [0:2],
    input  logic [DW+1:0]         i_num_mag [0:2],
    input  logic                  i_den_neg,
    input  logic [DW:0]           i_den_mag,
    output logic                  o_valid,
    output logic [SBW-1:0]        o_side,
    output logic                  o_neg [0:2],
    output logic [DW+FB+3:0]      o_quo [0:2]
);
    import qrs_pkg::*;

    localparam int NL   = 3;
    localparam int NW   = DW + 2;
    localparam int QW   = NW + FB + 2;
    localparam int D2W  = DW + 2;
    localparam int REMW = DW + 3;

    // prep stage: n = num * 2^(FB+1) + den, d = 2 * den
    logic           r_pvalid;
    logic [SBW-1:0] r_pside;
    logic [QW-1:0]  r_pn   [0:NL-1];
    logic           r_pneg [0:NL-1];
    logic [D2W-1:0] r_pd;

    logic           r_valid [1:QW];
    logic [SBW-1:0] r_side  [1:QW];
    logic           r_neg   [1:QW][0:NL-1];
    logic [QW-1:0]  r_q     [1:QW][0:NL-1];
    logic [QW-1:0]  r_n     [1:QW-1][0:NL-1];
    logic [REMW-1:0] r_rem  [1:QW-1][0:NL-1];
    logic [D2W-1:0] r_d     [1:QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pvalid <= 1'b0;
        else if (i_en)
            r_pvalid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pside <= i_side;
            r_pd    <= {i_den_mag, 1'b0};
            for (int l = 0; l < NL; l++) begin
                r_pn[l]   <= QW'({i_num_mag[l], {(FB+1){1'b0}}}) + QW'(i_den_mag);
                r_pneg[l] <= i_num_neg[l] ^ i_den_neg;
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic           v_in;
        logic [SBW-1:0] side_in;
        logic [D2W-1:0] d_in;

        if (k == 0) begin : g_first
            assign v_in    = r_pvalid;
            assign side_in = r_pside;
            assign d_in    = r_pd;
        end else begin : g_next
            assign v_in    = r_valid[k];
            assign side_in = r_side[k];
            assign d_in    = r_d[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_valid[k+1] <= 1'b0;
            else if (i_en)
                r_valid[k+1] <= v_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en)
                r_side[k+1] <= side_in;
        end

        if (k < QW - 1) begin : g_dcarry
            always_ff @(posedge i_clk) begin
                if (i_en)
                    r_d[k+1] <= d_in;
            end
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [QW-1:0]   n_in, q_in;
            logic [REMW-1:0] rem_in, cur;
            logic            neg_in, ge;

            if (k == 0) begin : g_first
                assign n_in   = r_pn[l];
                assign q_in   = '0;
                assign rem_in = '0;
                assign neg_in = r_pneg[l];
            end else begin : g_next
                assign n_in   = r_n[k][l];
                assign q_in   = r_q[k][l];
                assign rem_in = r_rem[k][l];
                assign neg_in = r_neg[k][l];
            end

            assign cur = {rem_in[REMW-2:0], n_in[QW-1]};
            assign ge  = cur >= {1'b0, d_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[k+1][l]   <= {q_in[QW-2:0], ge};
                    r_neg[k+1][l] <= neg_in;
                end
            end

            if (k < QW - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k+1][l] <= ge ? (cur - {1'b0, d_in}) : cur;
                        r_n[k+1][l]   <= {n_in[QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_valid[QW];
    assign o_side  = r_side[QW];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            o_neg[l] = r_neg[QW][l];
            o_quo[l] = r_q[QW][l];
        end
    end

endmodule
